@@ hw/rtl/tts_pkg.sv @@
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types and defaults of the tournament tree sorter: parameter
// defaults, the sequencer state type and the per-cell command group.
// ----------------------------------------------------------------------------
package tts_pkg;

    // parameter defaults
    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // width of the key fields on the ports
    localparam int IO_KEY_WIDTH = 32;

    // sequencer states
    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } tts_state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/tts_cell.sv @@
// ----------------------------------------------------------------------------
// tts_cell
// One slot of the sorting chain. On insert the cell keeps its key, takes
// the new key, or takes its lower neighbor's key so the row stays ascending.
// On shift it takes its upper neighbor's key, moving the row toward the head.
// ----------------------------------------------------------------------------
module tts_cell
    import tts_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctrl_t                  ctrl,
    input  logic signed [KEY_WIDTH-1:0] new_key,
    input  logic                        prev_gt,
    input  logic signed [KEY_WIDTH-1:0] prev_key,
    input  logic                        prev_valid,
    input  logic signed [KEY_WIDTH-1:0] next_key,
    input  logic                        next_valid,
    output logic                        gt_out,
    output logic signed [KEY_WIDTH-1:0] key,
    output logic                        valid
);

    logic signed [KEY_WIDTH-1:0] key_reg;
    logic signed [KEY_WIDTH-1:0] key_next;
    logic                        valid_reg;
    logic                        valid_next;

    // an empty slot ranks above every key
    assign gt_out = !valid_reg || (new_key < key_reg);

    // slot update
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
        else if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                key_next   = prev_key;
                valid_next = prev_valid;
            end
            else if (gt_out)
            begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // key storage
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

@@ hw/rtl/tournament_tree_sorter.sv @@
// ----------------------------------------------------------------------------
// tournament_tree_sorter
// Collects a set of signed keys and returns them in ascending order.
//
//   channel | valid / stall              | beat fields
//   --------+----------------------------+-----------------------------------
//   keys    | key_valid / key_stall      | in_key, is_last
//   sorted  | sorted_valid / sorted_stall| sorted_key, last_out, overflowed
//
// Loading takes one key per cycle; each key is placed into its ranked slot
// of a row of CAPACITY cells in that same cycle.
// The beat marked is_last starts the run; one sorted beat leaves per cycle
// as the row shifts toward its head, while the sorted side does not stall.
// key_stall is high for the whole run; a stall on the sorted side holds the
// row and the output register. Keys beyond CAPACITY are dropped and flagged.
// Reset empties the row and returns to loading; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tournament_tree_sorter
    import tts_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           key_valid,
    output logic                           key_stall,
    input  logic signed [IO_KEY_WIDTH-1:0] in_key,
    input  logic                           is_last,
    output logic                           sorted_valid,
    input  logic                           sorted_stall,
    output logic signed [IO_KEY_WIDTH-1:0] sorted_key,
    output logic                           last_out,
    output logic                           overflowed
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    tts_state_t                  state_reg;
    tts_state_t                  state_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        drop_reg;
    logic                        drop_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic signed [IO_KEY_WIDTH-1:0] out_key_reg;
    logic                        out_last_reg;
    logic                        out_ovf_reg;

    logic                        accept;
    logic                        room;
    logic                        take;
    logic                        final_take;
    cell_ctrl_t                  ctrl;
    logic signed [KEY_WIDTH-1:0] new_key;

    logic signed [KEY_WIDTH-1:0] cell_key   [0:CAPACITY];
    logic                        cell_valid [0:CAPACITY];
    logic                        gt_link    [0:CAPACITY-1];

    // key narrowed or sign-extended to the internal width
    assign new_key = KEY_WIDTH'(in_key);

    assign room       = count_reg < CNT_W'(CAPACITY);
    assign accept     = key_valid && !key_stall;
    assign take       = (state_reg == ST_EMIT) && (!out_valid_reg || !sorted_stall);
    assign final_take = take && (count_reg == CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (final_take)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        key_stall   = 1'b0;
        ctrl.insert = 1'b0;
        ctrl.shift  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                ctrl.insert = accept && room;
            end
            ST_EMIT:
            begin
                key_stall  = 1'b1;
                ctrl.shift = take;
            end
            default:
            begin
                key_stall = 1'b1;
            end
        endcase
    end

    // fill count and drop flag
    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept)
        begin
            drop_next = 1'b1;
        end
        if (take)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (final_take)
        begin
            drop_next = 1'b0;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!sorted_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_key_reg  <= IO_KEY_WIDTH'(cell_key[0]);
            out_last_reg <= (count_reg == CNT_W'(1));
            out_ovf_reg  <= drop_reg;
        end
    end

    // empty slot beyond the tail
    assign cell_key[CAPACITY]   = '0;
    assign cell_valid[CAPACITY] = 1'b0;
    assign gt_link[0]           = 1'b0;

    // row of cells
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            localparam int PREV = (i == 0) ? 0 : i - 1;
            if (i < CAPACITY - 1)
            begin : g_mid
                tts_cell #(
                    .KEY_WIDTH (KEY_WIDTH)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_key    (new_key),
                    .prev_gt    (gt_link[i]),
                    .prev_key   (cell_key[PREV]),
                    .prev_valid (cell_valid[PREV]),
                    .next_key   (cell_key[i+1]),
                    .next_valid (cell_valid[i+1]),
                    .gt_out     (gt_link[i+1]),
                    .key        (cell_key[i]),
                    .valid      (cell_valid[i])
                );
            end
            else
            begin : g_tail
                tts_cell #(
                    .KEY_WIDTH (KEY_WIDTH)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .new_key    (new_key),
                    .prev_gt    (gt_link[i]),
                    .prev_key   (cell_key[PREV]),
                    .prev_valid (cell_valid[PREV]),
                    .next_key   (cell_key[i+1]),
                    .next_valid (cell_valid[i+1]),
                    .gt_out     (),
                    .key        (cell_key[i]),
                    .valid      (cell_valid[i])
                );
            end
        end
    endgenerate

    assign sorted_valid = out_valid_reg;
    assign sorted_key   = out_key_reg;
    assign last_out     = out_last_reg;
    assign overflowed   = out_ovf_reg;

endmodule

@@ hw/rtl/tts_checker.sv @@
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the sorter: run framing against the key channel,
// a held sorted beat, and a steady overflow flag within a run.
// ----------------------------------------------------------------------------
module tts_checker
    import tts_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           key_valid,
    input logic                           key_stall,
    input logic                           is_last,
    input logic                           sorted_valid,
    input logic                           sorted_stall,
    input logic signed [IO_KEY_WIDTH-1:0] sorted_key,
    input logic                           last_out,
    input logic                           overflowed
);

    // a stalled sorted beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && sorted_stall |=> sorted_valid && $stable(sorted_key)
            && $stable(last_out))
    else $error("sorted beat changed under stall");

    // closing key starts a run that holds off new keys
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && !key_stall && is_last |=> key_stall)
    else $error("keys taken right after the closing beat");

    // keys stay held off until the final sorted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && !sorted_stall && !last_out |-> key_stall)
    else $error("keys taken in the middle of a run");

    // overflow flag is the same on every beat of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && !sorted_stall && !last_out |=>
            !sorted_valid || (overflowed == $past(overflowed)))
    else $error("overflow flag changed within a run");

endmodule

bind tournament_tree_sorter tts_checker u_tts_checker (.*);

@@ tb/sv/tb_tournament_tree_sorter.sv @@
// ----------------------------------------------------------------------------
// tb_tournament_tree_sorter
// Self-checking bench for the tournament tree sorter. Key sets are queued
// for a bursty driver; every accepted key beat feeds a ranked copy of the
// set, and the is_last beat turns that copy into the ascending run of
// sorted beats the block has to return, with the overflow flag where keys
// went past capacity. The sorted side stalls on random patterns plus one
// long hold-off that backs the block up into its key channel.
// ----------------------------------------------------------------------------
module tb_tournament_tree_sorter
    import tts_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SET_CAP      = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 420;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int SETTLE_WAIT  = 40;

    localparam logic signed [IO_KEY_WIDTH-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [IO_KEY_WIDTH-1:0] KEY_MIN = 32'sh8000_0000;

    // flavors of key content in a set
    typedef enum int {
        KF_FULL,
        KF_CLUSTER,
        KF_EXTREME,
        KF_MIXED
    } key_flavor_t;

    typedef struct {
        logic signed [IO_KEY_WIDTH-1:0] key;
        logic                           is_end;
    } key_beat_t;

    typedef struct {
        logic signed [IO_KEY_WIDTH-1:0] sorted_key;
        logic                           last_out;
        logic                           overflowed;
    } sorted_beat_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           key_valid    = 1'b0;
    logic                           key_stall;
    logic signed [IO_KEY_WIDTH-1:0] in_key       = '0;
    logic                           is_last      = 1'b0;
    logic                           sorted_valid;
    logic                           sorted_stall = 1'b0;
    logic signed [IO_KEY_WIDTH-1:0] sorted_key;
    logic                           last_out;
    logic                           overflowed;

    key_beat_t                      pending_beats[$];
    sorted_beat_t                   sorted_expect[$];
    logic signed [IO_KEY_WIDTH-1:0] run_keys[$];
    logic                           run_dropped = 1'b0;

    int err_count   = 0;
    int hold_req    = 0;
    int items_added = 0;

    tournament_tree_sorter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .in_key       (in_key),
        .is_last      (is_last),
        .sorted_valid (sorted_valid),
        .sorted_stall (sorted_stall),
        .sorted_key   (sorted_key),
        .last_out     (last_out),
        .overflowed   (overflowed)
    );

    // clock
    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // key content by flavor
    function automatic logic signed [IO_KEY_WIDTH-1:0] pick_key(key_flavor_t flavor);
        logic signed [IO_KEY_WIDTH-1:0] k;
        k = $urandom;
        case (flavor)
            KF_CLUSTER: k = $signed($urandom_range(0, 10)) - 5;
            KF_EXTREME:
            begin
                case ($urandom_range(0, 6))
                    0: k = KEY_MIN;
                    1: k = KEY_MIN + 1;
                    2: k = -1;
                    3: k = 0;
                    4: k = 1;
                    5: k = KEY_MAX - 1;
                    default: k = KEY_MAX;
                endcase
            end
            KF_MIXED:
            begin
                if ($urandom_range(0, 2) == 0)
                    k = pick_key(KF_EXTREME);
                else if ($urandom_range(0, 1) == 0)
                    k = pick_key(KF_CLUSTER);
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // queue one beat for the driver
    function automatic void push_key(logic signed [IO_KEY_WIDTH-1:0] k, logic is_end);
        key_beat_t b;
        b.key    = k;
        b.is_end = is_end;
        pending_beats.push_back(b);
        items_added++;
    endfunction

    // queue a whole set, the final beat closes it
    function automatic void push_random_set(int n_keys);
        key_flavor_t flavor;
        flavor = key_flavor_t'($urandom_range(0, 3));
        for (int i = 0; i < n_keys; i++)
            push_key(pick_key(flavor), i == n_keys - 1);
    endfunction

    // random sets until a number of items is reached; mostly in range, some overflowing
    function automatic void push_random_items(int n_items);
        int stop_at;
        int n_keys;
        stop_at = items_added + n_items;
        while (items_added < stop_at)
        begin
            case ($urandom_range(0, 9))
                0: n_keys = $urandom_range(SET_CAP + 1, SET_CAP + 6);
                1: n_keys = SET_CAP;
                2: n_keys = 1;
                default: n_keys = $urandom_range(2, SET_CAP - 1);
            endcase
            push_random_set(n_keys);
        end
    endfunction

    // sender pause: everything offered, accepted and returned
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || key_valid || sorted_expect.size() != 0);
    endtask

    // ranked copy of the open set
    function automatic void insert_ranked(logic signed [IO_KEY_WIDTH-1:0] k);
        int pos;
        pos = run_keys.size();
        for (int i = 0; i < run_keys.size(); i++)
        begin
            if (run_keys[i] > k)
            begin
                pos = i;
                break;
            end
        end
        run_keys.insert(pos, k);
    endfunction

    // accepted key beat: store or drop, and release the run on is_last
    function automatic void predict_sorted_run(logic signed [IO_KEY_WIDTH-1:0] k,
                                               logic is_end);
        sorted_beat_t e;
        if (run_keys.size() < SET_CAP)
            insert_ranked(k);
        else
            run_dropped = 1'b1;
        if (is_end)
        begin
            for (int i = 0; i < run_keys.size(); i++)
            begin
                e.sorted_key = run_keys[i];
                e.last_out   = (i == run_keys.size() - 1);
                e.overflowed = run_dropped;
                sorted_expect.push_back(e);
            end
            run_keys.delete();
            run_dropped = 1'b0;
        end
    endfunction

    // key driver: bursts of beats with random gaps
    always @(posedge clk or negedge rst_n)
    begin : key_driver
        int        gap_left;
        int        burst_left;
        key_beat_t nb;
        if (!rst_n)
        begin
            key_valid  <= 1'b0;
            in_key     <= '0;
            is_last    <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end
        else if (!key_valid || !key_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                key_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                nb = pending_beats.pop_front();
                in_key    <= nb.key;
                is_last   <= nb.is_end;
                key_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                key_valid <= 1'b0;
            end
        end
    end

    // predictor tap on the key channel
    always @(posedge clk)
    begin
        if (rst_n && key_valid && !key_stall)
            predict_sorted_run(in_key, is_last);
    end

    // sorted side stall pattern, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin : sorted_receiver
        int   hold_ack;
        int   hold_left;
        int   mode_left;
        int   stall_mode;
        logic nxt;
        if (!rst_n)
        begin
            sorted_stall <= 1'b0;
            hold_ack   = 0;
            hold_left  = 0;
            mode_left  = 0;
            stall_mode = 0;
        end
        else
        begin
            nxt = 1'b0;
            if (hold_ack != hold_req)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 120);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    1: nxt = ($urandom_range(0, 3) == 0);
                    2: nxt = ($urandom_range(0, 1) == 1);
                    3: nxt = ($urandom_range(0, 9) != 0);
                    default: nxt = 1'b0;
                endcase
            end
            sorted_stall <= nxt;
        end
    end

    // sorted beat checker
    always @(posedge clk)
    begin : sorted_checker
        sorted_beat_t e;
        if (rst_n && sorted_valid && !sorted_stall)
        begin
            if (sorted_expect.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected sorted beat: expected none, got key %0d last %0b ovf %0b",
                         $time, sorted_key, last_out, overflowed);
            end
            else
            begin
                e = sorted_expect.pop_front();
                if (sorted_key !== e.sorted_key || last_out !== e.last_out ||
                    overflowed !== e.overflowed)
                begin
                    err_count++;
                    $display("%0t sorted beat mismatch: expected key %0d last %0b ovf %0b, got key %0d last %0b ovf %0b",
                             $time, e.sorted_key, e.last_out, e.overflowed,
                             sorted_key, last_out, overflowed);
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if (!rst_n || (key_valid && !key_stall) || (sorted_valid && !sorted_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t watchdog: no beat for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, sorted_expect.size());
                $display("[tournament_tree_sorter] ERROR");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // single key, and it is the largest key
        push_key(KEY_MAX, 1'b1);
        // extremes with a duplicate
        push_key(KEY_MIN, 1'b0);
        push_key(-1, 1'b0);
        push_key(0, 1'b0);
        push_key(1, 1'b0);
        push_key(KEY_MAX, 1'b0);
        push_key(KEY_MIN, 1'b1);
        // full set in descending order, the closing beat is dropped
        for (int i = 0; i < SET_CAP; i++)
            push_key(KEY_MAX - i * 32'sh1000_0001, 1'b0);
        push_key(KEY_MIN, 1'b1);
        wait_for_drain();

        // long hold-off on the sorted side while keys keep coming
        hold_req++;
        push_random_items(RANDOM_ITEMS / 3);
        wait_for_drain();

        push_random_items(RANDOM_ITEMS / 3);
        wait_for_drain();

        push_random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_for_drain();

        repeat (SETTLE_WAIT) @(negedge clk);
        if (sorted_expect.size() != 0)
            err_count++;

        if (err_count == 0)
            $display("[tournament_tree_sorter] OK");
        else
            $display("[tournament_tree_sorter] ERROR");
        $finish;
    end

endmodule
